// ----- rtl/ali_pkg.sv -----
// Shared types, widths and codes for the array list block.
`timescale 1ns / 1ps

package ali_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;
    localparam int FPOS_W   = 3;
    localparam int LEN_W    = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef logic signed [WORD_W-1:0] word_t;

    // Command codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL         = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INSERT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETE_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd4;

    // Per-cell move control, decoded separately for each cell of the row.
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

// ----- rtl/ali_cell.sv -----
// One storage cell of the list row: holds an entry, shifts, and compares.
`timescale 1ns / 1ps

module ali_cell (
    input  logic               clk,
    input  ali_pkg::cell_ctrl_t ctrl,
    input  ali_pkg::word_t     new_value,
    input  ali_pkg::word_t     left_value,
    input  ali_pkg::word_t     right_value,
    input  ali_pkg::word_t     key,
    output ali_pkg::word_t     entry,
    output logic               match
);
    import ali_pkg::*;

    word_t entry_reg;

    // Payload only, so no reset; the count decides which cells hold data.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            entry_reg <= new_value;
        end
        else if (ctrl.take_left)
        begin
            entry_reg <= left_value;
        end
        else if (ctrl.take_right)
        begin
            entry_reg <= right_value;
        end
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);

endmodule

// ----- rtl/array_list_insert_delete_find_top.sv -----
// Top level of the array list: a row of shifting cells, a count and a result register.
// A command beat's result is registered and shows on the output in the cycle after the beat is accepted.
// Throughput: one command per cycle, but for the stall below; only the cells that a command moves shift or load.
// The input is stalled only while a result sits unread in the output register.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result;
// the stored words themselves are not cleared.
`timescale 1ns / 1ps

module array_list_insert_delete_find_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // From bit 0: position [3:0], value [35:4], zero fill [39:36].
    input  logic [ali_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode [1:0].
    input  logic [ali_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0: status [2:0], found_position [5:3], length [9:6], zero fill [15:10].
    output logic [ali_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import ali_pkg::*;

    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    word_t             value;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    logic              accept;
    logic              is_full;
    logic              ins_ok;
    logic              del_ok;
    logic [STAT_W-1:0] status;
    logic [FPOS_W-1:0] found_position;
    logic [LEN_W-1:0]  length;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;

    cell_ctrl_t        ctrl      [CAPACITY];
    word_t             entry     [CAPACITY];
    logic              match     [CAPACITY];
    word_t             left_val  [CAPACITY];
    word_t             right_val [CAPACITY];

    assign opcode   = s_axis_tuser;
    assign position = s_axis_tdata[POS_W-1:0];
    assign value    = word_t'(s_axis_tdata[POS_W +: WORD_W]);

    // The output register parts the two sides: a new command is taken whenever
    // the held result is empty or leaves in this cycle.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Legality of the command against the current count.
    always_comb
    begin
        is_full = (count_reg == CNT_W'(CAPACITY));
        ins_ok  = (opcode == OP_INSERT) && !is_full &&
                  ({{(CNT_W > POS_W ? CNT_W - POS_W : 0){1'b0}}, position} <=
                   {{(POS_W > CNT_W ? POS_W - CNT_W : 0){1'b0}}, count_reg});
        del_ok  = (opcode == OP_DELETE) &&
                  ({{(CNT_W > POS_W ? CNT_W - POS_W : 0){1'b0}}, position} <
                   {{(POS_W > CNT_W ? POS_W - CNT_W : 0){1'b0}}, count_reg});
    end

    // Neighbor wiring and per-cell control. On insert every cell above the
    // position takes its left neighbor; on delete every cell from the position
    // up takes its right neighbor. The top cell has no right neighbor, and
    // what it holds after a delete lies beyond the count anyway.
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_row
            if (k == 0)
            begin : g_first
                assign left_val[k] = entry[k];
            end
            else
            begin : g_mid
                assign left_val[k] = entry[k-1];
            end

            if (k == CAPACITY - 1)
            begin : g_last
                assign right_val[k] = entry[k];
            end
            else
            begin : g_inner
                assign right_val[k] = entry[k+1];
            end

            always_comb
            begin
                ctrl[k].load_new   = accept && ins_ok &&
                                     (position == POS_W'(k));
                ctrl[k].take_left  = accept && ins_ok &&
                                     (position < POS_W'(k));
                ctrl[k].take_right = accept && del_ok &&
                                     (position <= POS_W'(k));
            end

            ali_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[k]),
                .new_value   (value),
                .left_value  (left_val[k]),
                .right_value (right_val[k]),
                .key         (value),
                .entry       (entry[k]),
                .match       (match[k])
            );
        end
    endgenerate

    // Lowest filled cell that matches the key wins.
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i] && (CNT_W'(i) < count_reg))
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Result and next count.
    always_comb
    begin
        status         = ST_OK;
        found_position = '0;
        count_next     = count_reg;
        case (opcode)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else if (!ins_ok)
                begin
                    status = ST_BAD_INSERT;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (!del_ok)
                begin
                    status = ST_DELETE_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_FIND:
            begin
                if (hit_any)
                begin
                    found_position = FPOS_W'(hit_idx);
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        length = LEN_W'(count_next);
    end

    always_comb
    begin
        m_valid_next = accept || (m_valid_reg && !m_axis_tready);
        m_data_next  = m_data_reg;
        if (accept)
        begin
            m_data_next = {{(OUT_DATA_W - STAT_W - FPOS_W - LEN_W){1'b0}},
                           length, found_position, status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- rtl/ali_chk.sv -----
// Port-level checker for the array list top level, with its bind statement.
`timescale 1ns / 1ps

module ali_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ali_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import ali_pkg::*;

    logic [STAT_W-1:0] st;
    logic [FPOS_W-1:0] fp;
    logic [LEN_W-1:0]  len;

    assign st  = m_axis_tdata[STAT_W-1:0];
    assign fp  = m_axis_tdata[STAT_W +: FPOS_W];
    assign len = m_axis_tdata[STAT_W + FPOS_W +: LEN_W];

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // With no result pending the block must take commands.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Every accepted command beat puts a result beat on the output next cycle.
    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("command beat without a result beat");

    // A full report means the list holds its capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == ST_FULL) |-> (len == LEN_W'(CAPACITY)))
        else $error("full status with short list");

    // A nonzero match position lies inside the filled part of the list.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (fp != '0) |->
            (st == ST_OK) && ({1'b0, fp} < len))
        else $error("match position outside the list");

endmodule

bind array_list_insert_delete_find_top ali_chk u_ali_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_array_list_insert_delete_find_top.sv -----
// Self-checking testbench for the array list block: directed commands, then random ones.
`timescale 1ns / 1ps

module tb_array_list_insert_delete_find_top;

    import ali_pkg::*;

    // Opcode 3 has no command behind it; the block answers with status ok and the count.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_CYCLES    = 48;
    localparam int QUIET_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int N_DIRECTED     = 25;
    localparam int ITEMS_PER_PASS = 205;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FPOS_W-1:0] found_pos;
        logic [LEN_W-1:0]  length;
    } reply_t;

    // One directed command. When has_reply is set, the reply is typed in the row
    // and is used instead of the predicted one.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] val;
        logic              has_reply;
        logic [STAT_W-1:0] status;
        logic [FPOS_W-1:0] found_pos;
        logic [LEN_W-1:0]  length;
    } cmd_row_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // Shadow copy of the list, advanced once per accepted command beat.
    word_t       shadow_words [CAPACITY];
    int          shadow_len = 0;
    reply_t      pending_replies [$];

    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    bit          growing        = 1'b1;

    cmd_row_t directed_cmds [N_DIRECTED] = '{
        // Empty list: every failing case and the unused opcode.
        '{OP_FIND,    4'd0,  32'h0000_0000, 1'b1, ST_NOT_FOUND,    3'd0, 4'd0},
        '{OP_DELETE,  4'd0,  32'h0000_0000, 1'b1, ST_DELETE_EMPTY, 3'd0, 4'd0},
        '{OP_INSERT,  4'd1,  32'h0000_0005, 1'b1, ST_BAD_INSERT,   3'd0, 4'd0},
        '{OP_INSERT,  4'd15, 32'hFFFF_FFFF, 1'b1, ST_BAD_INSERT,   3'd0, 4'd0},
        '{OP_UNUSED,  4'd15, 32'hFFFF_FFFF, 1'b1, ST_OK,           3'd0, 4'd0},
        // Value extremes, inserted at the front and at the end.
        '{OP_INSERT,  4'd0,  32'h7FFF_FFFF, 1'b1, ST_OK,           3'd0, 4'd1},
        '{OP_INSERT,  4'd1,  32'h8000_0000, 1'b1, ST_OK,           3'd0, 4'd2},
        '{OP_INSERT,  4'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,           3'd0, 4'd3},
        // Find ignores the position field.
        '{OP_FIND,    4'd9,  32'h8000_0000, 1'b1, ST_OK,           3'd2, 4'd3},
        '{OP_INSERT,  4'd4,  32'h0000_0000, 1'b1, ST_BAD_INSERT,   3'd0, 4'd3},
        // Fill up to capacity, with a duplicate value in the middle.
        '{OP_INSERT,  4'd3,  32'h0000_0000, 1'b0, ST_OK,           3'd0, 4'd0},
        '{OP_INSERT,  4'd2,  32'h7FFF_FFFF, 1'b0, ST_OK,           3'd0, 4'd0},
        '{OP_INSERT,  4'd5,  32'h5555_5555, 1'b0, ST_OK,           3'd0, 4'd0},
        '{OP_INSERT,  4'd1,  32'hAAAA_AAAA, 1'b0, ST_OK,           3'd0, 4'd0},
        '{OP_INSERT,  4'd7,  32'h0000_0001, 1'b0, ST_OK,           3'd0, 4'd0},
        // Full list: insert fails whatever the position.
        '{OP_INSERT,  4'd0,  32'h0000_0002, 1'b1, ST_FULL,         3'd0, 4'd8},
        '{OP_INSERT,  4'd15, 32'h0000_0002, 1'b1, ST_FULL,         3'd0, 4'd8},
        '{OP_FIND,    4'd0,  32'h7FFF_FFFF, 1'b0, ST_OK,           3'd0, 4'd0},
        '{OP_FIND,    4'd0,  32'h0000_3039, 1'b1, ST_NOT_FOUND,    3'd0, 4'd8},
        // Delete past the end, then at the last and first slots.
        '{OP_DELETE,  4'd8,  32'h0000_0000, 1'b1, ST_DELETE_EMPTY, 3'd0, 4'd8},
        '{OP_DELETE,  4'd15, 32'h0000_0000, 1'b1, ST_DELETE_EMPTY, 3'd0, 4'd8},
        '{OP_DELETE,  4'd7,  32'h0000_0000, 1'b1, ST_OK,           3'd0, 4'd7},
        '{OP_DELETE,  4'd0,  32'h0000_0000, 1'b1, ST_OK,           3'd0, 4'd6},
        '{OP_UNUSED,  4'd0,  32'h0000_0000, 1'b1, ST_OK,           3'd0, 4'd6},
        '{OP_FIND,    4'd0,  32'hFFFF_FFFF, 1'b0, ST_OK,           3'd0, 4'd0}
    };

    array_list_insert_delete_find_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Applies one command to the shadow list and returns the reply it causes.
    function automatic reply_t list_apply(input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input word_t val);
        reply_t r;
        int     k;
        r.status    = ST_OK;
        r.found_pos = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(pos) > shadow_len)
                    r.status = ST_BAD_INSERT;
                else
                begin
                    for (k = shadow_len; k > int'(pos); k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos[IDX_W-1:0]] = val;
                    shadow_len++;
                end
            end
            OP_DELETE:
            begin
                if (int'(pos) >= shadow_len)
                    r.status = ST_DELETE_EMPTY;
                else
                begin
                    for (k = int'(pos); k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            OP_FIND:
            begin
                // Lowest filled position wins; unfilled slots are never looked at.
                r.status = ST_NOT_FOUND;
                for (k = 0; k < shadow_len && r.status != ST_OK; k++)
                begin
                    if (shadow_words[k] == val)
                    begin
                        r.status    = ST_OK;
                        r.found_pos = k[FPOS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    // Offers one command beat, after random idle cycles, and records its reply
    // once the beat is taken.
    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input word_t val, input logic has_reply, input reply_t typed);
        reply_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - WORD_W - POS_W){1'b0}}, val, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = list_apply(op, pos, val);
        pending_replies.push_back(has_reply ? typed : predicted);
    endtask

    // Stops offering and waits until every reply in flight has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Random commands. Mostly well-formed: the list swings between full and empty,
    // values repeat often so that find hits, and a share of positions is out of range.
    task automatic run_random(input int n_items);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        word_t            val;
        int               roll;
        repeat (n_items)
        begin
            if (shadow_len == CAPACITY)
                growing = 1'b0;
            else if (shadow_len == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = ~growing;

            roll = $urandom_range(99);
            if (roll < 5)
                op = OP_UNUSED;
            else if (roll < 30)
                op = OP_FIND;
            else if (roll < (growing ? 80 : 45))
                op = OP_INSERT;
            else
                op = OP_DELETE;

            if ($urandom_range(99) < 15)
                pos = POS_W'($urandom_range(15));
            else if (op == OP_DELETE && shadow_len > 0)
                pos = POS_W'($urandom_range(shadow_len - 1));
            else
                pos = POS_W'($urandom_range(shadow_len));

            roll = $urandom_range(99);
            if (shadow_len > 0 && roll < (op == OP_FIND ? 55 : 20))
                val = shadow_words[IDX_W'($urandom_range(shadow_len - 1))];
            else if (roll < 70)
            begin
                case ($urandom_range(7))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h7FFF_FFFF;
                    3: val = 32'h8000_0000;
                    4: val = 32'h0000_0001;
                    5: val = 32'h5555_5555;
                    6: val = 32'hAAAA_AAAA;
                    default: val = 32'h0000_0007;
                endcase
            end
            else
                val = $urandom;

            issue(op, pos, val, 1'b0, '0);
        end
    endtask

    // Result side: ready is random per cycle, except during a requested hold-off,
    // which this process times by itself so that the block backs up meanwhile.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_request = 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result beat is checked, field by field, against the oldest reply waiting.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status    = m_axis_tdata[2:0];
            got.found_pos = m_axis_tdata[5:3];
            got.length    = m_axis_tdata[9:6];
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result beat with nothing outstanding: status %0d pos %0d len %0d",
                             got.status, got.found_pos, got.length);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status != want.status || got.found_pos != want.found_pos
                    || got.length != want.length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: want status %0d pos %0d len %0d, got %0d %0d %0d",
                                 want.status, want.found_pos, want.length,
                                 got.status, got.found_pos, got.length);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL array_list_insert_delete_find_top");
        $finish;
    end

    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands with both sides running freely.
        for (i = 0; i < N_DIRECTED; i++)
            issue(directed_cmds[i].op, directed_cmds[i].pos, directed_cmds[i].val,
                  directed_cmds[i].has_reply,
                  '{directed_cmds[i].status, directed_cmds[i].found_pos,
                    directed_cmds[i].length});
        wait_drained();

        run_random(ITEMS_PER_PASS);

        // Back-pressure: results are refused for a long stretch while commands keep coming.
        hold_request = 1'b1;
        run_random(14);
        wait_drained();

        send_idle_pct = 79;
        run_random(ITEMS_PER_PASS);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 79;
        run_random(ITEMS_PER_PASS);

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(ITEMS_PER_PASS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("PASS array_list_insert_delete_find_top");
        else
            $display("FAIL array_list_insert_delete_find_top");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ali_pkg.sv
rtl/ali_cell.sv
rtl/array_list_insert_delete_find_top.sv
rtl/ali_chk.sv
tb/tb_array_list_insert_delete_find_top.sv
